// File: src/audio_channel_matrix_mixer_defines.svh
// assertion macros shared by the mixer checker
`ifndef AUDIO_CHANNEL_MATRIX_MIXER_DEFINES_SVH
`define AUDIO_CHANNEL_MATRIX_MIXER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ACMM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ACMM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/acmm_pkg.sv
// shared constants and types of the channel matrix mixer
package acmm_pkg;

  // parameter defaults
  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_MAX_TERMS    = 8;
  localparam int DEF_SAMPLE_BITS  = 24;

  // fixed field widths
  localparam int OP_W      = 2;
  localparam int CHAN_W    = 3;
  localparam int SRC_W     = 3;
  localparam int LEVEL_W   = 16;
  localparam int TERMS_W   = 4;
  localparam int COUNT_W   = 4;
  localparam int MASK_W    = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  // level is Q2.14, rounding adds half an lsb before the shift
  localparam int LEVEL_SHIFT  = 14;
  localparam int RESULT_LIMIT = 8;

  // operation codes carried in in_tuser
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_TERM   = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IN_COUNT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_COUNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_MASK  = 2'd2;

  // configuration reset values
  localparam logic [COUNT_W-1:0] RST_IN_COUNT  = 4'd2;
  localparam logic [COUNT_W-1:0] RST_OUT_COUNT = 4'd2;
  localparam logic [MASK_W-1:0]  RST_OUT_MASK  = 8'hff;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

// File: src/acmm_ram.sv
// generic simple dual-port ram with registered read
module acmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/acmm_mac.sv
// shared multiply-accumulate unit with rounding and saturation
module acmm_mac
  import acmm_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int MAX_TERMS   = DEF_MAX_TERMS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mac_ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [LEVEL_W-1:0]            level_i,
  output logic                          busy_o,
  output logic signed [SAMPLE_BITS-1:0] result_o
);

  localparam int PROD_W = SAMPLE_BITS + LEVEL_W + 1;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TERMS) + 1;
  localparam int SHR_W  = ACC_W - LEVEL_SHIFT;

  logic signed [PROD_W-1:0] product_r;
  logic signed [PROD_W-1:0] product_nxt;
  logic                     mul_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [SHR_W-1:0]  shifted;
  logic [SHR_W-SAMPLE_BITS:0] top_bits;

  // multiply stage, level treated as a positive signed operand
  assign product_nxt = sample_i * $signed({1'b0, level_i});

  always_ff @(posedge clk) begin
    product_r <= product_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= ctrl_i.valid;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctrl_i.clear) begin
      acc_r <= '0;
    end else if (mul_vld_r) begin
      acc_r <= acc_r + ACC_W'(product_r);
    end
  end

  assign busy_o = mul_vld_r;

  // round half up, floor shift, then clamp to the sample range
  assign rounded  = acc_r + ACC_W'(1 << (LEVEL_SHIFT - 1));
  assign shifted  = rounded[ACC_W-1:LEVEL_SHIFT];
  assign top_bits = shifted[SHR_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      result_o = shifted[SAMPLE_BITS-1:0];
    end else if (shifted[SHR_W-1]) begin
      result_o = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

endmodule

// File: src/audio_channel_matrix_mixer.sv
// channel matrix mixer top level: frame store, term tables and output sequencer
//
// Interleaved samples arrive one channel per transaction (in_tuser = sample op)
// and fill a frame store; load transactions write the per-output term table
// (source channel, unsigned Q2.14 level) and each output's term count. The
// sample that closes a frame starts the sequencer, which produces one result
// per output channel, in order, with out_tlast on the final one. A disabled
// output or one with no terms gives zero, a single-term output copies its
// source unchanged, any other output gives the rounded, saturated sum of
// source times level. Load items and samples that do not close a frame are
// accepted without a stall. A closing sample keeps in_tready low while the
// outputs are worked out: the term table is read one term a cycle through the
// single ram port into the one shared multiply-accumulate unit, then the
// pipeline drains and the result is handed off; a disabled or empty output
// skips the reads, and out_tready can hold back a result. The last result may
// still wait in the output register while the next transactions are accepted.
module audio_channel_matrix_mixer
  import acmm_pkg::*;
#(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_TERMS    = DEF_MAX_TERMS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // input stream
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // sample_in, target_output, term_slot, source_channel, mix_level, terms_in_use
  input  logic [((SAMPLE_BITS + 29 + 7) / 8) * 8 - 1:0] in_tdata,
  // operation
  input  logic [OP_W-1:0]                            in_tuser,
  // result stream
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // output_channel, sample_out
  output logic [((SAMPLE_BITS + 3 + 7) / 8) * 8 - 1:0]  out_tdata,
  output logic                                       out_tlast,
  // configuration write port
  input  logic                                       cfg_we,
  input  logic [CFG_ADDR_W-1:0]                      cfg_addr,
  input  logic [CFG_DATA_W-1:0]                      cfg_wdata
);

  localparam int OUT_DATA_W = ((SAMPLE_BITS + 3 + 7) / 8) * 8;
  localparam int CH_W       = $clog2(MAX_CHANNELS);
  localparam int CNT_W      = $clog2(MAX_TERMS + 1);
  localparam int DEPTH      = MAX_CHANNELS * MAX_TERMS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int TERM_W     = SRC_W + LEVEL_W;
  localparam int OUT_LIMIT  = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;

  // in_tdata field offsets
  localparam int OFS_TGT   = SAMPLE_BITS;
  localparam int OFS_SLOT  = OFS_TGT + CHAN_W;
  localparam int OFS_SRC   = OFS_SLOT + CHAN_W;
  localparam int OFS_LVL   = OFS_SRC + SRC_W;
  localparam int OFS_TERMS = OFS_LVL + LEVEL_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  // configuration
  logic [COUNT_W-1:0] in_cnt_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic [MASK_W-1:0]  en_mask_r;

  // frame store and term counts
  logic signed [SAMPLE_BITS-1:0] fs_r [MAX_CHANNELS];
  logic [CNT_W-1:0]              cnt_r [MAX_CHANNELS];

  // sequencer
  logic [2:0]        state_r, state_nxt;
  logic [CHAN_W-1:0] oidx_r, oidx_nxt;
  logic [CNT_W-1:0]  tidx_r, tidx_nxt;
  logic [CH_W-1:0]   pos_r, pos_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic signed [SAMPLE_BITS-1:0] copy_r;

  // output register
  logic                          out_valid_r;
  logic [CHAN_W-1:0]             out_chan_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_last_r;
  logic                          out_load;

  // input fields
  logic [OP_W-1:0]               in_op;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [CHAN_W-1:0]             in_target;
  logic [CHAN_W-1:0]             in_slot;
  logic [SRC_W-1:0]              in_src;
  logic [LEVEL_W-1:0]            in_level;
  logic [TERMS_W-1:0]            in_terms;
  logic                          in_acc;

  // derived control
  logic [4:0]         nin_eff;
  logic [COUNT_W-1:0] nout_eff;
  logic               frame_done;
  logic               is_last;
  logic [CH_W-1:0]    o_ch;
  logic [CNT_W-1:0]   cur_cnt;
  logic               cur_en;
  logic               skip_out;
  logic signed [SAMPLE_BITS-1:0] res_sample;

  // term table ram
  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_waddr;
  logic [ADDR_W-1:0] tbl_raddr;
  logic              tbl_re;
  logic [TERM_W-1:0] tbl_rdata;
  logic [SRC_W-1:0]  rd_src;
  logic [LEVEL_W-1:0] rd_level;
  logic signed [SAMPLE_BITS-1:0] src_sample;
  logic              cnt_we;
  logic [CNT_W-1:0]  cnt_wval;

  // mac unit
  mac_ctrl_t                     mac_ctrl;
  logic                          mac_busy;
  logic signed [SAMPLE_BITS-1:0] mac_result;

  // unpack input transaction
  assign in_op     = in_tuser;
  assign in_sample = in_tdata[SAMPLE_BITS-1:0];
  assign in_target = in_tdata[OFS_SLOT-1:OFS_TGT];
  assign in_slot   = in_tdata[OFS_SRC-1:OFS_SLOT];
  assign in_src    = in_tdata[OFS_LVL-1:OFS_SRC];
  assign in_level  = in_tdata[OFS_TERMS-1:OFS_LVL];
  assign in_terms  = in_tdata[OFS_TERMS+TERMS_W-1:OFS_TERMS];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= RST_IN_COUNT;
      out_cnt_r <= RST_OUT_COUNT;
      en_mask_r <= RST_OUT_MASK;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IN_COUNT:  in_cnt_r  <= cfg_wdata[COUNT_W-1:0];
        REG_OUT_COUNT: out_cnt_r <= cfg_wdata[COUNT_W-1:0];
        REG_OUT_MASK:  en_mask_r <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // effective channel counts
  always_comb begin
    if (in_cnt_r == '0) begin
      nin_eff = 5'd1;
    end else if (int'(in_cnt_r) > MAX_CHANNELS) begin
      nin_eff = 5'(MAX_CHANNELS);
    end else begin
      nin_eff = 5'(in_cnt_r);
    end
    if (out_cnt_r == '0) begin
      nout_eff = COUNT_W'(1);
    end else if (int'(out_cnt_r) > OUT_LIMIT) begin
      nout_eff = COUNT_W'(OUT_LIMIT);
    end else begin
      nout_eff = out_cnt_r;
    end
  end

  assign frame_done = (5'(pos_r) + 5'd1) >= nin_eff;
  assign is_last    = (COUNT_W'(oidx_r) + COUNT_W'(1)) == nout_eff;

  // current output's settings
  assign o_ch     = CH_W'(oidx_r);
  assign cur_cnt  = cnt_r[o_ch];
  assign cur_en   = en_mask_r[oidx_r];
  assign skip_out = !cur_en || (cur_cnt == '0);

  // load transactions into the term tables
  assign tbl_we    = in_acc && (in_op == OP_TERM) && (int'(in_target) < MAX_CHANNELS)
                     && (int'(in_slot) < MAX_TERMS);
  assign tbl_waddr = ADDR_W'(int'(in_target) * MAX_TERMS + int'(in_slot));
  assign cnt_we    = in_acc && (in_op == OP_COUNT) && (int'(in_target) < MAX_CHANNELS);
  assign cnt_wval  = (int'(in_terms) > MAX_TERMS) ? CNT_W'(MAX_TERMS) : CNT_W'(in_terms);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cnt_we) begin
      cnt_r[CH_W'(in_target)] <= cnt_wval;
    end
  end

  // frame store write at the running channel position
  always_ff @(posedge clk) begin
    if (in_acc && (in_op == OP_SAMPLE)) begin
      fs_r[pos_r] <= in_sample;
    end
  end

  // term table read port
  assign tbl_raddr = ADDR_W'(int'(oidx_r) * MAX_TERMS + int'(tidx_r));

  acmm_ram #(
    .WIDTH (TERM_W),
    .DEPTH (DEPTH)
  ) u_term_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata ({in_level, in_src}),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign rd_src   = tbl_rdata[SRC_W-1:0];
  assign rd_level = tbl_rdata[TERM_W-1:SRC_W];

  // source lookup, positions beyond the store read zero
  always_comb begin
    if (int'(rd_src) >= MAX_CHANNELS) begin
      src_sample = '0;
    end else begin
      src_sample = fs_r[CH_W'(rd_src)];
    end
  end

  // single-term outputs copy the source as is
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      copy_r <= src_sample;
    end
  end

  acmm_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TERMS   (MAX_TERMS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_i   (mac_ctrl),
    .sample_i (src_sample),
    .level_i  (rd_level),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  // result select for the current output
  always_comb begin
    if (skip_out) begin
      res_sample = '0;
    end else if (cur_cnt == CNT_W'(1)) begin
      res_sample = copy_r;
    end else begin
      res_sample = mac_result;
    end
  end

  // output sequencer
  always_comb begin
    state_nxt      = state_r;
    oidx_nxt       = oidx_r;
    tidx_nxt       = tidx_r;
    pos_nxt        = pos_r;
    rd_vld_nxt     = 1'b0;
    tbl_re         = 1'b0;
    out_load       = 1'b0;
    mac_ctrl.clear = 1'b0;
    mac_ctrl.valid = rd_vld_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_SAMPLE)) begin
          if (frame_done) begin
            pos_nxt   = '0;
            oidx_nxt  = '0;
            state_nxt = ST_START;
          end else begin
            pos_nxt = pos_r + CH_W'(1);
          end
        end
      end
      ST_START: begin
        mac_ctrl.clear = 1'b1;
        tidx_nxt       = '0;
        state_nxt      = skip_out ? ST_EMIT : ST_ISSUE;
      end
      ST_ISSUE: begin
        tbl_re     = 1'b1;
        rd_vld_nxt = 1'b1;
        tidx_nxt   = tidx_r + CNT_W'(1);
        if (tidx_r == cur_cnt - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !mac_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            oidx_nxt  = oidx_r + CHAN_W'(1);
            state_nxt = ST_START;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      oidx_r   <= '0;
      tidx_r   <= '0;
      pos_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oidx_r   <= oidx_nxt;
      tidx_r   <= tidx_nxt;
      pos_r    <= pos_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan_r   <= oidx_r;
      out_sample_r <= res_sample;
      out_last_r   <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_sample_r, out_chan_r});
  assign out_tlast  = out_last_r;

endmodule

// File: src/acmm_checker.sv
// port-level checker for the channel matrix mixer, bound to the top level
`include "audio_channel_matrix_mixer_defines.svh"

module acmm_checker
  import acmm_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input logic                                      clk,
  input logic                                      rst_n,
  input logic                                      in_tvalid,
  input logic                                      in_tready,
  input logic [OP_W-1:0]                           in_tuser,
  input logic                                      out_tvalid,
  input logic                                      out_tready,
  input logic [((SAMPLE_BITS + 3 + 7) / 8) * 8 - 1:0] out_tdata,
  input logic                                      out_tlast
);

  // a stalled result holds
  `ACMM_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // no result pending right after reset
  `ACMM_ASSERT_IMP(a_reset_empty, $past(!rst_n), !out_tvalid, "result valid after reset")

  // mid-frame results keep the input side closed
  `ACMM_ASSERT_IMP(a_busy_mid_frame, out_tvalid && !out_tlast, !in_tready, "input accepted mid frame")

  // the highest output channel always closes the frame
  `ACMM_ASSERT_IMP(a_top_chan_last, out_tvalid && (out_tdata[2:0] == 3'd7), out_tlast, "channel 7 not last")

  // load transactions produce no result
  `ACMM_ASSERT_NXT(a_load_silent, in_tvalid && in_tready && (in_tuser != OP_SAMPLE) && !out_tvalid, !out_tvalid, "result after load transaction")

endmodule

bind audio_channel_matrix_mixer acmm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_acmm_checker (.*);
